FILE: hw/rtl/assert_macros.svh
// assertion macros for the checksum core rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must hold at every clock edge out of reset
`define CKS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("checksum core assertion failed");
// antecedent implies consequent in the same cycle or a later one
`define CKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("checksum core assertion failed");
`else
`define CKS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define CKS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/cks_pkg.sv
// types, constants and ones'-complement helper for the checksum core
// no dependencies; used by every module of the core
package cks_pkg;

	localparam logic [15:0] WORD_MASK  = 16'hffff;
	localparam logic [15:0] HDR_LEN    = 16'd20;
	localparam logic [15:0] ADDR_START = 16'd12;
	localparam logic [15:0] ADDR_BYTES = 16'd8;
	localparam logic [15:0] ADDR_END   = ADDR_START + ADDR_BYTES;

	// one input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] upper_proto;
		logic       pkt_last;
	} cks_item_t;

	// packet totals handed to the finishing stage
	typedef struct packed {
		logic [15:0] header_sum;
		logic [15:0] upper_sum;
		logic [15:0] upper_len;
		logic [7:0]  upper_proto;
		logic        short_packet;
	} cks_fin_t;

	// ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

	// complement, keeping an all-zero sum at zero
	function automatic logic [15:0] oc_finish(input logic [15:0] sum);
		return (sum == 16'd0) ? 16'd0 : ~sum;
	endfunction

endpackage

FILE: hw/rtl/cks_accum.sv
// per-byte accumulation stage: packet state, header and upper sums
// depends on cks_pkg; feeds the packet totals register to cks_final
module cks_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s1_valid,
	input  cks_pkg::cks_item_t  s1_item,
	output logic                s1_take,
	output logic                s2_valid,
	output cks_pkg::cks_fin_t   s2_fin,
	input  logic                s2_take
);
	import cks_pkg::*;

	logic [15:0] header_sum_q;
	logic [15:0] upper_sum_q;
	logic [15:0] byte_count_q;
	logic [15:0] total_length_q;
	logic [7:0]  held_high_byte_q;
	logic        s2_valid_q;
	cks_fin_t    fin_s2;

	logic [15:0] end_old, end_new, tl_next, cnt_next, word, pos, acc;
	logic [15:0] hsum_next, usum_next;
	logic [7:0]  held_next;
	logic        in_range, add_data, add_pad, short_pkt, add_hdr, add_up, s2_free;

	// handshake between this stage and the totals register
	assign s2_free  = !s2_valid_q || s2_take;
	assign s1_take  = s1_valid && (!s1_item.pkt_last || s2_free);
	assign s2_valid = s2_valid_q;
	assign s2_fin   = fin_s2;

	// byte position decode and one word add per sum
	always_comb begin
		end_old   = (total_length_q < HDR_LEN) ? HDR_LEN : total_length_q;
		in_range  = byte_count_q < end_old;
		add_data  = in_range && byte_count_q[0];
		held_next = (in_range && !byte_count_q[0]) ? s1_item.data_byte : held_high_byte_q;
		tl_next   = (add_data && byte_count_q == 16'd3) ?
			{held_high_byte_q, s1_item.data_byte} : total_length_q;
		cnt_next  = (byte_count_q == WORD_MASK) ? byte_count_q : byte_count_q + 16'd1;
		end_new   = (tl_next < HDR_LEN) ? HDR_LEN : tl_next;
		short_pkt = cnt_next < end_new;
		acc       = short_pkt ? cnt_next : end_new;
		// a dangling high byte gets a zero low byte at packet end
		add_pad   = s1_item.pkt_last && acc[0];
		word      = add_data ? {held_high_byte_q, s1_item.data_byte} : {held_next, 8'h00};
		pos       = add_data ? (byte_count_q - 16'd1) : (acc - 16'd1);
		add_hdr   = (add_data || add_pad) && (pos < HDR_LEN);
		add_up    = (add_data || add_pad) &&
			((pos >= HDR_LEN) || (pos >= ADDR_START && pos < ADDR_END));
		hsum_next = add_hdr ? oc_add(header_sum_q, word) : header_sum_q;
		usum_next = add_up ? oc_add(upper_sum_q, word) : upper_sum_q;
	end

	// packet state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_sum_q     <= '0;
			upper_sum_q      <= '0;
			byte_count_q     <= '0;
			total_length_q   <= '0;
			held_high_byte_q <= '0;
		end else if (s1_take) begin
			if (s1_item.pkt_last) begin
				header_sum_q     <= '0;
				upper_sum_q      <= '0;
				byte_count_q     <= '0;
				total_length_q   <= '0;
				held_high_byte_q <= '0;
			end else begin
				header_sum_q     <= hsum_next;
				upper_sum_q      <= usum_next;
				byte_count_q     <= cnt_next;
				total_length_q   <= tl_next;
				held_high_byte_q <= held_next;
			end
		end
	end

	// packet totals register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid && s1_item.pkt_last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid && s1_item.pkt_last) begin
			fin_s2.header_sum   <= hsum_next;
			fin_s2.upper_sum    <= usum_next;
			fin_s2.upper_len    <= tl_next - HDR_LEN;
			fin_s2.upper_proto  <= s1_item.upper_proto;
			fin_s2.short_packet <= short_pkt;
		end
	end

endmodule

FILE: hw/rtl/cks_final.sv
// finishing stage: pseudo-header length and protocol, complement, result register
// depends on cks_pkg; takes packet totals from cks_accum
module cks_final (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s2_valid,
	input  cks_pkg::cks_fin_t  s2_fin,
	output logic               s2_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        ip_checksum,
	output logic [15:0]        upper_checksum,
	output logic               short_packet
);
	import cks_pkg::*;

	logic        out_valid_q;
	logic [15:0] ip_checksum_q;
	logic [15:0] upper_checksum_q;
	logic        short_packet_q;
	logic [15:0] usum_len, usum_all;

	assign s2_take        = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign ip_checksum    = ip_checksum_q;
	assign upper_checksum = upper_checksum_q;
	assign short_packet   = short_packet_q;

	// pseudo-header upper length and protocol
	always_comb begin
		usum_len = oc_add(s2_fin.upper_sum, s2_fin.upper_len);
		usum_all = oc_add(usum_len, {8'h00, s2_fin.upper_proto});
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && s2_valid) begin
			ip_checksum_q    <= oc_finish(s2_fin.header_sum);
			upper_checksum_q <= oc_finish(usum_all);
			short_packet_q   <= s2_fin.short_packet;
		end
	end

endmodule

FILE: hw/rtl/ipv4_tcp_udp_checksum_core.sv
// top level of the ipv4 header and tcp/udp checksum core
// depends on cks_pkg, cks_accum, cks_final and assert_macros.svh
//
// Takes an IPv4 packet one byte per item, IP header first, checksum fields
// zeroed, and on the item marked last gives the IP header checksum and the
// TCP/UDP checksum (pseudo-header included) as big-endian words, plus a flag
// when the stream ended before the IP total length. Bytes past the total
// length are ignored; upper_proto is sampled on the last byte. One byte is
// accepted every cycle while in_ready is high; the last byte passes from the
// input register through the accumulation stage (one ones'-complement adder
// per sum) into the totals register, then through the finishing stage (the
// pseudo-header adds) into the result register. Ready drops only when a
// last byte meets a full totals register and a stalled result.
`include "assert_macros.svh"
module ipv4_tcp_udp_checksum_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  upper_proto,
	input  logic        pkt_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] ip_checksum,
	output logic [15:0] upper_checksum,
	output logic        short_packet
);
	import cks_pkg::*;

	logic      s1_valid_q;
	cks_item_t item_s1;
	logic      s1_take;
	logic      s2_valid;
	cks_fin_t  s2_fin;
	logic      s2_take;

	// input register
	assign in_ready = !s1_valid_q || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data_byte   <= data_byte;
			item_s1.upper_proto <= upper_proto;
			item_s1.pkt_last    <= pkt_last;
		end
	end

	cks_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid_q),
		.s1_item  (item_s1),
		.s1_take  (s1_take),
		.s2_valid (s2_valid),
		.s2_fin   (s2_fin),
		.s2_take  (s2_take)
	);

	cks_final u_final (
		.clk            (clk),
		.arst_n         (arst_n),
		.s2_valid       (s2_valid),
		.s2_fin         (s2_fin),
		.s2_take        (s2_take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ip_checksum    (ip_checksum),
		.upper_checksum (upper_checksum),
		.short_packet   (short_packet)
	);

	// a last byte leaving the input register fills the totals register
	`CKS_ASSERT_IMPL(a_last_fills_s2, clk, arst_n, s1_take && item_s1.pkt_last, ##1 s2_valid)
	// a new result only follows packet totals
	`CKS_ASSERT_IMPL(a_out_from_s2, clk, arst_n, $rose(out_valid), $past(s2_valid))
	// stalling input only with an item held in the input register
	`CKS_ASSERT_IMPL(a_stall_has_item, clk, arst_n, !in_ready, s1_valid_q && s2_valid)

endmodule
